[hdl/lpcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcs_pkg
// shared types, constants and rom tables of the lpc speech synthesizer
// ----------------------------------------------------------------------------
package lpcs_pkg;

  localparam int BUFFER_BITS = 64;
  localparam int CNT_W       = $clog2(BUFFER_BITS + 1);
  localparam int CHIRP_LEN   = 41;
  localparam int NUM_K       = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNDERRUN = 2'd1;
  localparam logic [1:0] ERR_FULL     = 2'd2;

  localparam logic [1:0] REG_SPS   = 2'd0;
  localparam logic [1:0] REG_SPF   = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  localparam logic [3:0] FLD_ENERGY = 4'd0;
  localparam logic [3:0] FLD_REPEAT = 4'd1;
  localparam logic [3:0] FLD_PITCH  = 4'd2;
  localparam logic [3:0] FLD_K1     = 4'd3;
  localparam logic [3:0] FLD_K4     = 4'd6;
  localparam logic [3:0] FLD_K10    = 4'd12;

  localparam logic [3:0] ENERGY_REST = 4'h0;
  localparam logic [3:0] ENERGY_STOP = 4'hf;
  localparam logic [15:0] NOISE_TAPS = 16'hB800;
  localparam logic [15:0] NOISE_SEED = 16'h0001;
  localparam logic [9:0]  SAMPLE_MID = 10'd512;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_PUSH,
    KIND_TICK,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] samples_per_subframe;
    logic [7:0] subframes_per_frame;
    logic [2:0] interp_shift;
  } cfg_t;

  typedef struct packed {
    logic [9:0]       sample;
    logic             speaking;
    logic [CNT_W-1:0] buffered_bits;
    logic [1:0]       error;
  } result_t;

  function automatic logic [2:0] field_len(input logic [3:0] fid);
    case (fid)
      4'd0:                   field_len = 3'd4;
      4'd1:                   field_len = 3'd1;
      4'd2:                   field_len = 3'd6;
      4'd3, 4'd4:             field_len = 3'd5;
      4'd5, 4'd6, 4'd7, 4'd8, 4'd9: field_len = 3'd4;
      default:                field_len = 3'd3;
    endcase
  endfunction

  function automatic logic [7:0] energy_rom(input logic [3:0] i);
    case (i)
      4'd0: energy_rom = 8'h00;  4'd1: energy_rom = 8'h02;
      4'd2: energy_rom = 8'h03;  4'd3: energy_rom = 8'h04;
      4'd4: energy_rom = 8'h05;  4'd5: energy_rom = 8'h07;
      4'd6: energy_rom = 8'h0a;  4'd7: energy_rom = 8'h0f;
      4'd8: energy_rom = 8'h14;  4'd9: energy_rom = 8'h20;
      4'd10: energy_rom = 8'h29; 4'd11: energy_rom = 8'h39;
      4'd12: energy_rom = 8'h51; 4'd13: energy_rom = 8'h72;
      4'd14: energy_rom = 8'ha1; default: energy_rom = 8'hff;
    endcase
  endfunction

  function automatic logic [7:0] period_rom(input logic [5:0] i);
    logic [7:0] t [64];
    t = '{8'h00,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,
          8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,
          8'h27,8'h28,8'h29,8'h2A,8'h2B,8'h2D,8'h2F,8'h31,8'h33,8'h35,8'h36,8'h39,
          8'h3B,8'h3D,8'h3F,8'h42,8'h45,8'h47,8'h49,8'h4D,8'h4F,8'h51,8'h55,8'h57,
          8'h5C,8'h5F,8'h63,8'h66,8'h6A,8'h6E,8'h73,8'h77,8'h7B,8'h80,8'h85,8'h8A,
          8'h8F,8'h95,8'h9A,8'hA0};
    period_rom = t[i];
  endfunction

  function automatic logic signed [7:0] chirp_rom(input logic [5:0] i);
    logic signed [7:0] t [CHIRP_LEN];
    t = '{8'sd0,8'sd42,-8'sd44,8'sd50,-8'sd78,8'sd18,8'sd37,8'sd20,8'sd2,-8'sd31,
          -8'sd59,8'sd2,8'sd95,8'sd90,8'sd5,8'sd15,8'sd38,-8'sd4,-8'sd91,-8'sd91,
          -8'sd42,-8'sd35,-8'sd36,-8'sd4,8'sd37,8'sd43,8'sd34,8'sd33,8'sd15,-8'sd1,
          -8'sd8,-8'sd18,-8'sd19,-8'sd17,-8'sd9,-8'sd10,-8'sd6,8'sd0,8'sd3,8'sd2,
          8'sd1};
    if (i < 6'(CHIRP_LEN)) chirp_rom = t[i];
    else chirp_rom = 8'sd0;
  endfunction

  // coefficient value for field fid (k1..k10) at index v
  function automatic logic [15:0] k_rom(input logic [3:0] fid, input logic [4:0] v);
    logic [15:0] k1 [32];
    logic [15:0] k2 [32];
    logic [7:0]  k3 [16];
    logic [7:0]  k4 [16];
    logic [7:0]  k5 [16];
    logic [7:0]  k6 [16];
    logic [7:0]  k7 [16];
    logic [7:0]  k8 [8];
    logic [7:0]  k9 [8];
    logic [7:0]  k10 [8];
    k1 = '{16'h82C0,16'h8380,16'h83C0,16'h8440,16'h84C0,16'h8540,16'h8600,16'h8780,
           16'h8880,16'h8980,16'h8AC0,16'h8C00,16'h8D40,16'h8F00,16'h90C0,16'h92C0,
           16'h9900,16'hA140,16'hAB80,16'hB840,16'hC740,16'hD8C0,16'hEBC0,16'h0000,
           16'h1440,16'h2740,16'h38C0,16'h47C0,16'h5480,16'h5EC0,16'h6700,16'h6D40};
    k2 = '{16'hAE00,16'hB480,16'hBB80,16'hC340,16'hCB80,16'hD440,16'hDDC0,16'hE780,
           16'hF180,16'hFBC0,16'h0600,16'h1040,16'h1A40,16'h2400,16'h2D40,16'h3600,
           16'h3E40,16'h45C0,16'h4CC0,16'h5300,16'h5880,16'h5DC0,16'h6240,16'h6640,
           16'h69C0,16'h6CC0,16'h6F80,16'h71C0,16'h73C0,16'h7580,16'h7700,16'h7E80};
    k3 = '{8'(-110),8'(-97),8'(-83),8'(-70),8'(-56),8'(-43),8'(-29),8'(-16),
           8'(-2),8'd11,8'd25,8'd38,8'd52,8'd65,8'd79,8'd92};
    k4 = '{8'(-82),8'(-68),8'(-54),8'(-40),8'(-26),8'(-12),8'd1,8'd15,
           8'd29,8'd43,8'd57,8'd71,8'd85,8'd99,8'd113,8'd126};
    k5 = '{8'(-82),8'(-70),8'(-59),8'(-47),8'(-35),8'(-24),8'(-12),8'(-1),
           8'd11,8'd23,8'd34,8'd46,8'd57,8'd69,8'd81,8'd92};
    k6 = '{8'(-64),8'(-53),8'(-42),8'(-31),8'(-20),8'(-9),8'd3,8'd14,
           8'd25,8'd36,8'd47,8'd58,8'd69,8'd80,8'd91,8'd102};
    k7 = '{8'(-77),8'(-65),8'(-53),8'(-41),8'(-29),8'(-17),8'(-5),8'd7,
           8'd19,8'd31,8'd43,8'd55,8'd67,8'd79,8'd90,8'd102};
    k8 = '{8'(-64),8'(-40),8'(-16),8'd7,8'd31,8'd55,8'd79,8'd102};
    k9 = '{8'(-64),8'(-44),8'(-24),8'(-4),8'd16,8'd37,8'd57,8'd77};
    k10 = '{8'(-51),8'(-33),8'(-15),8'd4,8'd22,8'd32,8'd59,8'd77};
    case (fid)
      4'd3:    k_rom = k1[v];
      4'd4:    k_rom = k2[v];
      4'd5:    k_rom = {k3[v[3:0]], 8'h00};
      4'd6:    k_rom = {k4[v[3:0]], 8'h00};
      4'd7:    k_rom = {k5[v[3:0]], 8'h00};
      4'd8:    k_rom = {k6[v[3:0]], 8'h00};
      4'd9:    k_rom = {k7[v[3:0]], 8'h00};
      4'd10:   k_rom = {k8[v[2:0]], 8'h00};
      4'd11:   k_rom = {k9[v[2:0]], 8'h00};
      default: k_rom = {k10[v[2:0]], 8'h00};
    endcase
  endfunction

endpackage

[hdl/lpc_speech_synthesizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_speech_synthesizer
// ten-coefficient lpc speech decoder with bit buffer and q15 lattice
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time by a single
// sequencer. Start, push and a tick while silent go straight from accept to
// the result state. A speaking tick runs the excitation, with an extra scaling
// step when a chirp sample has to be scaled, and the ten-stage lattice forward
// and backward through one shared registered multiplier. A subframe update adds
// one-coefficient-a-cycle interpolation (a direct load after a start or stop),
// and a frame read takes one bitstream bit per cycle (up to 50 bits). The next
// request can be queued while a result waits on the output.
module lpc_speech_synthesizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // action[1:0], data_byte[9:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // sample[9:0], speaking[10], buffered_bits[17:11],
                                  // error[19:18]
);
  import lpcs_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    q_valid;
  req_t    q_req;
  logic    q_pop;
  result_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SPS:   cfg_nxt.samples_per_subframe = cfg_wdata;
        REG_SPF:   cfg_nxt.subframes_per_frame  = cfg_wdata;
        REG_SHIFT: cfg_nxt.interp_shift         = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_subframe <= 8'd25;
      cfg_r.subframes_per_frame  <= 8'd8;
      cfg_r.interp_shift         <= 3'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lpcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  lpcs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {4'd0, res.error, res.buffered_bits, res.speaking, res.sample};

endmodule

[hdl/lpcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcs_front
// accepts input requests, classifies the action and queues them for the engine
// ----------------------------------------------------------------------------
module lpcs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,
  output logic                 q_valid,
  output lpcs_pkg::req_t       q_req,
  input  logic                 q_pop
);
  import lpcs_pkg::*;

  req_t       mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  req_t       cls;
  logic       push;

  always_comb begin
    case (in_tdata[1:0])
      ACT_START: cls.kind = KIND_START;
      ACT_PUSH:  cls.kind = KIND_PUSH;
      ACT_TICK:  cls.kind = KIND_TICK;
      default:   cls.kind = KIND_NOP;
    endcase
    cls.data_byte = in_tdata[9:2];
  end

  assign in_tready = (fill_r != 2'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_req     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !q_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[hdl/lpcs_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcs_engine
// bit buffer, frame parser, interpolator and lattice filter on one multiplier
// ----------------------------------------------------------------------------
module lpcs_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpcs_pkg::cfg_t         cfg,
  input  logic                   q_valid,
  input  lpcs_pkg::req_t         q_req,
  output logic                   q_pop,
  output logic                   res_valid,
  output lpcs_pkg::result_t      res,
  input  logic                   res_ready
);
  import lpcs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_BIT    = 10'b0000000010,
    S_INTERP = 10'b0000000100,
    S_EXC    = 10'b0000001000,
    S_ESCL   = 10'b0000010000,
    S_FMUL   = 10'b0000100000,
    S_FACC   = 10'b0001000000,
    S_BMUL   = 10'b0010000000,
    S_BACC   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [BUFFER_BITS-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    speaking_r, speaking_nxt;
  logic                    first_r, first_nxt;
  logic [7:0]              tick_r, tick_nxt;
  logic [7:0]              sub_r, sub_nxt;
  logic [7:0]              tgt_e_r, tgt_e_nxt;
  logic [7:0]              cur_e_r, cur_e_nxt;
  logic [7:0]              tgt_p_r, tgt_p_nxt;
  logic [7:0]              cur_p_r, cur_p_nxt;
  logic [7:0]              pitch_r, pitch_nxt;
  logic [15:0]             noise_r, noise_nxt;
  logic signed [15:0]      tgt_k_r [NUM_K];
  logic signed [15:0]      tgt_k_nxt [NUM_K];
  logic signed [15:0]      cur_k_r [NUM_K];
  logic signed [15:0]      cur_k_nxt [NUM_K];
  logic signed [15:0]      bwd_r [NUM_K];
  logic signed [15:0]      bwd_nxt [NUM_K];
  logic signed [15:0]      fwd_r [NUM_K];
  logic signed [15:0]      fwd_nxt [NUM_K];
  logic signed [15:0]      acc_r, acc_nxt;
  logic [9:0]              last_r, last_nxt;
  logic [1:0]              err_r, err_nxt;
  logic [3:0]              idx_r, idx_nxt;
  logic [3:0]              fid_r, fid_nxt;
  logic [2:0]              flen_r, flen_nxt;
  logic [5:0]              fval_r, fval_nxt;
  logic                    rep_r, rep_nxt;
  logic                    out_valid_r, out_valid_nxt;
  result_t                 out_r, out_nxt;
  logic signed [16:0]      mul_a, mul_b;
  logic signed [33:0]      prod_r;

  logic                    bit_v;
  logic [5:0]              fv;
  logic [BUFFER_BITS-1:0]  buf_c;
  logic [CNT_W-1:0]        cnt_c;
  logic signed [8:0]       de, dp;
  logic signed [16:0]      dk;
  logic signed [15:0]      fsum, bsum;
  logic [7:0]              pc;
  logic [15:0]             nz;
  logic signed [9:0]       clamp;

  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    speaking_nxt  = speaking_r;
    first_nxt     = first_r;
    tick_nxt      = tick_r;
    sub_nxt       = sub_r;
    tgt_e_nxt     = tgt_e_r;
    cur_e_nxt     = cur_e_r;
    tgt_p_nxt     = tgt_p_r;
    cur_p_nxt     = cur_p_r;
    pitch_nxt     = pitch_r;
    noise_nxt     = noise_r;
    tgt_k_nxt     = tgt_k_r;
    cur_k_nxt     = cur_k_r;
    bwd_nxt       = bwd_r;
    fwd_nxt       = fwd_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    idx_nxt       = idx_r;
    fid_nxt       = fid_r;
    flen_nxt      = flen_r;
    fval_nxt      = fval_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    bit_v = (cnt_r == '0) ? 1'b0 : buf_r[0];
    fv    = {fval_r[4:0], bit_v};
    buf_c = (cnt_r == '0) ? buf_r : (buf_r >> 1);
    cnt_c = (cnt_r == '0) ? cnt_r : (cnt_r - CNT_W'(1));
    de    = 9'($signed({1'b0, tgt_e_r}) - $signed({1'b0, cur_e_r})) >>> cfg.interp_shift;
    dp    = 9'($signed({1'b0, tgt_p_r}) - $signed({1'b0, cur_p_r})) >>> cfg.interp_shift;
    dk    = ($signed({tgt_k_r[idx_r][15], tgt_k_r[idx_r]}) -
             $signed({cur_k_r[idx_r][15], cur_k_r[idx_r]})) >>> cfg.interp_shift;
    fsum  = acc_r - $signed(prod_r[30:15]);
    bsum  = bwd_r[idx_r - 4'd1] + $signed(prod_r[30:15]);
    pc    = (pitch_r < cur_p_r) ? (pitch_r + 8'd1) : 8'd0;
    nz    = (noise_r >> 1) ^ (noise_r[0] ? NOISE_TAPS : 16'h0000);
    if (fsum > 16'sd511) clamp = 10'sd511;
    else if (fsum < -16'sd512) clamp = -10'sd512;
    else clamp = fsum[9:0];

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          err_nxt = ERR_NONE;
          state_nxt = S_DONE;
          case (q_req.kind)
            KIND_START: begin
              buf_nxt      = buf_r >> cnt_r[2:0];
              cnt_nxt      = cnt_r - CNT_W'(cnt_r[2:0]);
              speaking_nxt = 1'b1;
              first_nxt    = 1'b1;
            end
            KIND_PUSH: begin
              if (cnt_r > CNT_W'(BUFFER_BITS - 8)) begin
                err_nxt = ERR_FULL;
              end else begin
                buf_nxt = buf_r | (BUFFER_BITS'(q_req.data_byte) << cnt_r);
                cnt_nxt = cnt_r + CNT_W'(8);
              end
            end
            KIND_TICK: begin
              if (!speaking_r) begin
                last_nxt = SAMPLE_MID;
              end else if (tick_r + 8'd1 == cfg.samples_per_subframe) begin
                tick_nxt = 8'd0;
                idx_nxt  = 4'd0;
                if (sub_r + 8'd1 == cfg.subframes_per_frame) begin
                  sub_nxt   = 8'd0;
                  fid_nxt   = FLD_ENERGY;
                  flen_nxt  = field_len(FLD_ENERGY);
                  fval_nxt  = '0;
                  state_nxt = S_BIT;
                end else begin
                  sub_nxt   = sub_r + 8'd1;
                  state_nxt = S_INTERP;
                end
              end else begin
                tick_nxt  = tick_r + 8'd1;
                state_nxt = S_EXC;
              end
            end
            default: ;
          endcase
        end
      end
      S_BIT: begin
        if (cnt_r == '0) err_nxt = ERR_UNDERRUN;
        buf_nxt  = buf_c;
        cnt_nxt  = cnt_c;
        fval_nxt = fv;
        flen_nxt = flen_r - 3'd1;
        if (flen_r == 3'd1) begin
          fid_nxt  = fid_r + 4'd1;
          flen_nxt = field_len(fid_r + 4'd1);
          fval_nxt = '0;
          case (fid_r)
            FLD_ENERGY: begin
              if (fv[3:0] == ENERGY_REST) begin
                tgt_e_nxt = 8'd0;
                state_nxt = S_INTERP;
              end else if (fv[3:0] == ENERGY_STOP) begin
                tgt_e_nxt    = 8'd0;
                for (int i = 0; i < NUM_K; i++) tgt_k_nxt[i] = '0;
                speaking_nxt = 1'b0;
                buf_nxt      = buf_c >> cnt_c[2:0];
                cnt_nxt      = cnt_c - CNT_W'(cnt_c[2:0]);
                first_nxt    = 1'b1;
                sub_nxt      = 8'd0;
                tick_nxt     = 8'd0;
                state_nxt    = S_INTERP;
              end else begin
                tgt_e_nxt = energy_rom(fv[3:0]);
              end
            end
            FLD_REPEAT: rep_nxt = bit_v;
            FLD_PITCH: begin
              tgt_p_nxt = period_rom(fv);
              if (rep_r) state_nxt = S_INTERP;
            end
            default: begin
              tgt_k_nxt[fid_r - FLD_K1] = $signed(k_rom(fid_r, fv[4:0]));
              if ((fid_r == FLD_K4 && tgt_p_r == 8'd0) || fid_r == FLD_K10) begin
                state_nxt = S_INTERP;
              end
            end
          endcase
        end
      end
      S_INTERP: begin
        if (first_r) begin
          first_nxt = 1'b0;
          cur_p_nxt = tgt_p_r;
          cur_e_nxt = tgt_e_r;
          cur_k_nxt = tgt_k_r;
          state_nxt = S_EXC;
        end else begin
          if (idx_r == 4'd0) begin
            cur_e_nxt = cur_e_r + de[7:0];
            cur_p_nxt = cur_p_r + dp[7:0];
          end
          cur_k_nxt[idx_r] = cur_k_r[idx_r] + dk[15:0];
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'(NUM_K - 1)) state_nxt = S_EXC;
        end
      end
      S_EXC: begin
        idx_nxt = 4'(NUM_K - 1);
        if (cur_p_r != 8'd0) begin
          pitch_nxt = pc;
          mul_a     = 17'(chirp_rom(pc[5:0]));
          mul_b     = $signed({9'd0, cur_e_r});
          if (pc < 8'(CHIRP_LEN)) begin
            state_nxt = S_ESCL;
          end else begin
            acc_nxt   = '0;
            state_nxt = S_FMUL;
          end
        end else begin
          noise_nxt = nz;
          acc_nxt   = nz[0] ? $signed({8'd0, cur_e_r}) : -$signed({8'd0, cur_e_r});
          state_nxt = S_FMUL;
        end
      end
      S_ESCL: begin
        acc_nxt   = $signed(prod_r[23:8]);
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        mul_a     = 17'(cur_k_r[idx_r]);
        mul_b     = 17'(bwd_r[idx_r]);
        state_nxt = S_FACC;
      end
      S_FACC: begin
        acc_nxt        = fsum;
        fwd_nxt[idx_r] = fsum;
        if (idx_r == 4'd0) begin
          fwd_nxt[0] = 16'(clamp);
          idx_nxt    = 4'(NUM_K - 1);
          state_nxt  = S_BMUL;
        end else begin
          idx_nxt   = idx_r - 4'd1;
          state_nxt = S_FMUL;
        end
      end
      S_BMUL: begin
        mul_a     = 17'(cur_k_r[idx_r - 4'd1]);
        mul_b     = 17'(fwd_r[idx_r - 4'd1]);
        state_nxt = S_BACC;
      end
      S_BACC: begin
        bwd_nxt[idx_r] = bsum;
        idx_nxt        = idx_r - 4'd1;
        state_nxt      = S_BMUL;
        if (idx_r == 4'd1) begin
          bwd_nxt[0] = fwd_r[0];
          last_nxt   = {~fwd_r[0][9], fwd_r[0][8:0]};
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.sample         = last_r;
          out_nxt.speaking       = speaking_r;
          out_nxt.buffered_bits  = cnt_r;
          out_nxt.error          = err_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_r       <= '0;
      cnt_r       <= '0;
      speaking_r  <= 1'b0;
      first_r     <= 1'b0;
      tick_r      <= 8'd0;
      sub_r       <= 8'd0;
      tgt_e_r     <= 8'd0;
      cur_e_r     <= 8'd0;
      tgt_p_r     <= 8'd0;
      cur_p_r     <= 8'd0;
      pitch_r     <= 8'd0;
      noise_r     <= NOISE_SEED;
      last_r      <= SAMPLE_MID;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_K; i++) begin
        tgt_k_r[i] <= '0;
        cur_k_r[i] <= '0;
        bwd_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      speaking_r  <= speaking_nxt;
      first_r     <= first_nxt;
      tick_r      <= tick_nxt;
      sub_r       <= sub_nxt;
      tgt_e_r     <= tgt_e_nxt;
      cur_e_r     <= cur_e_nxt;
      tgt_p_r     <= tgt_p_nxt;
      cur_p_r     <= cur_p_nxt;
      pitch_r     <= pitch_nxt;
      noise_r     <= noise_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      tgt_k_r     <= tgt_k_nxt;
      cur_k_r     <= cur_k_nxt;
      bwd_r       <= bwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r  <= fwd_nxt;
    acc_r  <= acc_nxt;
    err_r  <= err_nxt;
    idx_r  <= idx_nxt;
    fid_r  <= fid_nxt;
    flen_r <= flen_nxt;
    fval_r <= fval_nxt;
    rep_r  <= rep_nxt;
    out_r  <= out_nxt;
    prod_r <= mul_a * mul_b;
  end

endmodule
